FILE: rtl/qs3w_pkg.sv
// Package with the shared command and status types of the three-way quicksort engine.
`default_nettype none
package qs3w_pkg;
	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_INIT,
		OP_POP,
		OP_RANGE,
		OP_LAT_PIV,
		OP_RD_CUR,
		OP_CMP,
		OP_SWAP_RD,
		OP_SWAP_WR,
		OP_SWAP_WB,
		OP_FIN_RD,
		OP_FIN_HOLD,
		OP_PUSH_L,
		OP_PUSH_R,
		OP_OUT_RD,
		OP_OUT_NEXT
	} op_t;

	typedef struct packed {
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic stack_empty;
		logic range_ok;
		logic scan_done;
		logic cmp_equal;
		logic push_left;
		logic push_right;
		logic out_last;
	} status_t;
endpackage
`default_nettype wire

FILE: rtl/qs3w_if.sv
// Valid/ready channel interface carrying one record per request.
`default_nettype none
interface qs3w_if #(
	parameter int KeyW = 32
);
	logic                   valid;
	logic                   ready;
	logic signed [KeyW-1:0] key;
	logic        [31:0]     payload;
	logic                   last;
	modport source (output valid, key, payload, last, input ready);
	modport sink (input valid, key, payload, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/qs3w_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module qs3w_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: rtl/qs3w_datapath.sv
// Datapath: record store, range stack, partition indices and output register.
`default_nettype none
module qs3w_datapath #(
	parameter int MaxElems = 64,
	parameter int KeyBits  = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire qs3w_pkg::cmd_t      cmd,
	output qs3w_pkg::status_t        status,
	input  wire logic [31:0]         in_key,
	input  wire logic [31:0]         in_payload,
	output logic [31:0]              out_key,
	output logic [31:0]              out_payload
);
	localparam int IdxW = $clog2(MaxElems);
	localparam int CntW = IdxW + 1;
	localparam int RecW = KeyBits + 32;
	localparam int StkW = 2 * IdxW;

	logic [CntW-1:0] count_q;
	logic [CntW-1:0] sp_q;
	logic [IdxW-1:0] lo_q, hi_q, lt_q, cur_q, gt_q, out_q;
	logic [IdxW-1:0] swp_a_q, swp_b_q;
	logic [KeyBits-1:0] piv_q;
	logic [RecW-1:0] hold_q;
	logic            less_q;

	logic            store_full, stk_room;
	logic            rec_we;
	logic [IdxW-1:0] rec_addr;
	logic [RecW-1:0] rec_wdata, rec_rdata;
	logic            stk_we;
	logic [IdxW-1:0] stk_addr;
	logic [StkW-1:0] stk_wdata, stk_rdata;
	logic [KeyBits-1:0] key_ext, cur_b, piv_b;
	logic            cmp_less, cmp_equal;

	assign store_full = (count_q == CntW'(MaxElems));
	assign stk_room   = (sp_q < CntW'(MaxElems));
	// Wider keys are zero-extended, narrower ones keep their low bits.
	assign key_ext    = KeyBits'(in_key);
	// Flipping the sign bit turns the signed order into an unsigned one.
	assign cur_b      = rec_rdata[RecW-1:32] ^ {1'b1, {(KeyBits-1){1'b0}}};
	assign piv_b      = piv_q ^ {1'b1, {(KeyBits-1){1'b0}}};
	assign cmp_less   = (cur_b < piv_b);
	assign cmp_equal  = (cur_b == piv_b);

	// Record memory address and write data per operation.
	always_comb begin
		rec_we    = 1'b0;
		rec_addr  = cur_q;
		rec_wdata = hold_q;
		unique case (cmd.op)
			qs3w_pkg::OP_LOAD: begin
				rec_we    = !store_full;
				rec_addr  = count_q[IdxW-1:0];
				rec_wdata = {key_ext, in_payload};
			end
			qs3w_pkg::OP_RANGE: rec_addr = stk_rdata[StkW-1:IdxW];
			qs3w_pkg::OP_SWAP_RD: rec_addr = swp_a_q;
			qs3w_pkg::OP_SWAP_WR: begin
				// The held record takes the place of the one just read.
				rec_we    = 1'b1;
				rec_addr  = swp_a_q;
				rec_wdata = hold_q;
			end
			qs3w_pkg::OP_SWAP_WB: begin
				rec_we    = 1'b1;
				rec_addr  = swp_b_q;
				rec_wdata = hold_q;
			end
			qs3w_pkg::OP_FIN_RD: rec_addr = gt_q;
			qs3w_pkg::OP_OUT_RD: rec_addr = out_q;
			default: ;
		endcase
	end

	qs3w_ram #(.Width(RecW), .Depth(MaxElems)) u_rec (
		.clk, .we(rec_we), .addr(rec_addr), .wdata(rec_wdata), .rdata(rec_rdata)
	);

	always_comb begin
		stk_we    = 1'b0;
		stk_addr  = IdxW'(sp_q - CntW'(1));
		stk_wdata = {hi_q, lo_q};
		unique case (cmd.op)
			qs3w_pkg::OP_INIT: begin
				stk_we    = 1'b1;
				stk_addr  = '0;
				stk_wdata = {IdxW'(count_q - CntW'(1)), {IdxW{1'b0}}};
			end
			qs3w_pkg::OP_PUSH_L: begin
				stk_we    = stk_room;
				stk_addr  = sp_q[IdxW-1:0];
				stk_wdata = {lt_q - IdxW'(1), lo_q};
			end
			qs3w_pkg::OP_PUSH_R: begin
				stk_we    = stk_room;
				stk_addr  = sp_q[IdxW-1:0];
				stk_wdata = {hi_q, gt_q + IdxW'(1)};
			end
			default: ;
		endcase
	end

	qs3w_ram #(.Width(StkW), .Depth(MaxElems)) u_stk (
		.clk, .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sp_q    <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			lt_q    <= '0;
			cur_q   <= '0;
			gt_q    <= '0;
			out_q   <= '0;
			swp_a_q <= '0;
			swp_b_q <= '0;
			piv_q   <= '0;
			hold_q  <= '0;
			less_q  <= 1'b0;
		end else begin
			case (cmd.op)
				qs3w_pkg::OP_LOAD: if (!store_full) count_q <= count_q + CntW'(1);
				qs3w_pkg::OP_INIT: begin
					sp_q  <= (count_q > CntW'(1)) ? CntW'(1) : '0;
					out_q <= '0;
				end
				qs3w_pkg::OP_POP: sp_q <= sp_q - CntW'(1);
				qs3w_pkg::OP_RANGE: begin
					lo_q  <= stk_rdata[IdxW-1:0];
					hi_q  <= stk_rdata[StkW-1:IdxW];
					lt_q  <= stk_rdata[IdxW-1:0];
					cur_q <= stk_rdata[IdxW-1:0];
					gt_q  <= stk_rdata[StkW-1:IdxW];
				end
				qs3w_pkg::OP_LAT_PIV: piv_q <= rec_rdata[RecW-1:32];
				qs3w_pkg::OP_CMP: begin
					hold_q  <= rec_rdata;
					swp_b_q <= cur_q;
					if (cmp_less) begin
						less_q  <= 1'b1;
						swp_a_q <= lt_q;
					end else if (cmp_equal) begin
						cur_q <= cur_q + IdxW'(1);
					end else begin
						less_q  <= 1'b0;
						swp_a_q <= gt_q - IdxW'(1);
						gt_q    <= gt_q - IdxW'(1);
					end
				end
				qs3w_pkg::OP_SWAP_WR: hold_q <= rec_rdata;
				qs3w_pkg::OP_SWAP_WB: begin
					if (less_q) begin
						lt_q  <= lt_q + IdxW'(1);
						cur_q <= cur_q + IdxW'(1);
					end
				end
				qs3w_pkg::OP_FIN_RD: begin
					// The pivot moves to the end of the equal block.
					swp_a_q <= hi_q;
					swp_b_q <= gt_q;
					less_q  <= 1'b0;
				end
				qs3w_pkg::OP_FIN_HOLD: hold_q <= rec_rdata;
				qs3w_pkg::OP_PUSH_L, qs3w_pkg::OP_PUSH_R: begin
					if (stk_room) sp_q <= sp_q + CntW'(1);
				end
				qs3w_pkg::OP_OUT_NEXT: begin
					out_q <= out_q + IdxW'(1);
					if (CntW'(out_q) + CntW'(1) == count_q) begin
						count_q <= '0;
						sp_q    <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register is loaded from the memory read that OP_OUT_RD started.
	always_ff @(posedge clk) begin
		if (cmd.op == qs3w_pkg::OP_OUT_NEXT) begin
			out_key     <= 32'(rec_rdata[RecW-1:32]);
			out_payload <= rec_rdata[31:0];
		end
	end

	always_comb begin
		status.stack_empty = (sp_q == '0);
		status.range_ok    = (stk_rdata[IdxW-1:0] < stk_rdata[StkW-1:IdxW]);
		status.scan_done   = !(cur_q < gt_q);
		status.cmp_equal   = cmp_equal;
		status.push_left   = (CntW'(lt_q) > CntW'(lo_q) + CntW'(1));
		status.push_right  = (CntW'(gt_q) + CntW'(1) < CntW'(hi_q));
		status.out_last    = (CntW'(out_q) + CntW'(1) == count_q);
	end
endmodule
`default_nettype wire

FILE: rtl/qs3w_ctrl.sv
// Controller state machine sequencing load, partition passes and output.
`default_nettype none
module qs3w_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_last,
	output logic                    in_ready,
	output logic                    out_valid,
	output logic                    out_last,
	input  wire logic               out_ready,
	input  wire qs3w_pkg::status_t  status,
	output qs3w_pkg::cmd_t          cmd
);
	typedef enum logic [4:0] {
		S_LOAD, S_INIT, S_POP, S_RANGE, S_PIV, S_SCAN, S_CMP,
		S_SWAP_RD, S_SWAP_WR, S_SWAP_WB, S_FIN_RD, S_FIN_HOLD, S_FIN_SRD,
		S_FIN_SWR, S_FIN_SWB, S_PUSH_L, S_PUSH_R, S_OUT_RD, S_OUT_LAT, S_OUT_HOLD
	} state_t;

	state_t state_q, nxt;
	logic   ov_q, ol_q;

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = ov_q;
	assign out_last  = ol_q;

	always_comb begin
		cmd.op = qs3w_pkg::OP_NOP;
		nxt    = state_q;
		unique case (state_q)
			S_LOAD: if (in_valid) begin
				cmd.op = qs3w_pkg::OP_LOAD;
				if (in_last) nxt = S_INIT;
			end
			S_INIT: begin cmd.op = qs3w_pkg::OP_INIT; nxt = S_POP; end
			S_POP: begin
				if (status.stack_empty) begin
					nxt = S_OUT_RD;
				end else begin
					cmd.op = qs3w_pkg::OP_POP;
					nxt    = S_RANGE;
				end
			end
			S_RANGE: begin
				if (status.range_ok) begin
					cmd.op = qs3w_pkg::OP_RANGE;
					nxt    = S_PIV;
				end else begin
					nxt = S_POP;
				end
			end
			S_PIV: begin cmd.op = qs3w_pkg::OP_LAT_PIV; nxt = S_SCAN; end
			S_SCAN: begin
				if (status.scan_done) begin
					nxt = S_FIN_RD;
				end else begin
					cmd.op = qs3w_pkg::OP_RD_CUR;
					nxt    = S_CMP;
				end
			end
			S_CMP: begin
				cmd.op = qs3w_pkg::OP_CMP;
				nxt    = status.cmp_equal ? S_SCAN : S_SWAP_RD;
			end
			S_SWAP_RD: begin cmd.op = qs3w_pkg::OP_SWAP_RD; nxt = S_SWAP_WR; end
			S_SWAP_WR: begin cmd.op = qs3w_pkg::OP_SWAP_WR; nxt = S_SWAP_WB; end
			S_SWAP_WB: begin cmd.op = qs3w_pkg::OP_SWAP_WB; nxt = S_SCAN; end
			S_FIN_RD: begin cmd.op = qs3w_pkg::OP_FIN_RD; nxt = S_FIN_HOLD; end
			S_FIN_HOLD: begin cmd.op = qs3w_pkg::OP_FIN_HOLD; nxt = S_FIN_SRD; end
			S_FIN_SRD: begin cmd.op = qs3w_pkg::OP_SWAP_RD; nxt = S_FIN_SWR; end
			S_FIN_SWR: begin cmd.op = qs3w_pkg::OP_SWAP_WR; nxt = S_FIN_SWB; end
			S_FIN_SWB: begin cmd.op = qs3w_pkg::OP_SWAP_WB; nxt = S_PUSH_L; end
			S_PUSH_L: begin
				if (status.push_left) cmd.op = qs3w_pkg::OP_PUSH_L;
				nxt = S_PUSH_R;
			end
			S_PUSH_R: begin
				if (status.push_right) cmd.op = qs3w_pkg::OP_PUSH_R;
				nxt = S_POP;
			end
			S_OUT_RD: begin cmd.op = qs3w_pkg::OP_OUT_RD; nxt = S_OUT_LAT; end
			S_OUT_LAT: begin cmd.op = qs3w_pkg::OP_OUT_NEXT; nxt = S_OUT_HOLD; end
			S_OUT_HOLD: if (out_ready) nxt = ol_q ? S_LOAD : S_OUT_RD;
			default: nxt = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ov_q    <= 1'b0;
			ol_q    <= 1'b0;
		end else begin
			state_q <= nxt;
			if (state_q == S_OUT_LAT) begin
				ov_q <= 1'b1;
				ol_q <= status.out_last;
			end else if (state_q == S_OUT_HOLD && out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/quicksort_three_way_engine_core.sv
// Top level of the three-way partition quicksort engine.
`default_nettype none
// Records are loaded one per cycle into an internal store of MAX_ELEMS entries;
// records beyond capacity are dropped. The request marked last starts an
// in-place quicksort (last element pivot, three-way partition, range stack in
// a RAM). Each scanned element is read and compared, and swapped when its key
// differs from the pivot, through the single record RAM port. Once sorted,
// the records leave in ascending key order, one at a time, each read only
// after the one before it has been taken, the last one flagged by last.
// No input is taken while sorting or emitting.
module quicksort_three_way_engine_core #(
	parameter int MAX_ELEMS = 64,
	parameter int KEY_BITS  = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	qs3w_if.sink     in_ch,
	qs3w_if.source   out_ch
);
	qs3w_pkg::cmd_t    cmd;
	qs3w_pkg::status_t status;
	logic [31:0]       okey;

	qs3w_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_last(in_ch.last), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_last(out_ch.last), .out_ready(out_ch.ready),
		.status, .cmd
	);

	qs3w_datapath #(.MaxElems(MAX_ELEMS), .KeyBits(KEY_BITS)) u_dp (
		.clk, .arst_n, .cmd, .status,
		.in_key(32'(in_ch.key)), .in_payload(in_ch.payload),
		.out_key(okey), .out_payload(out_ch.payload)
	);

	assign out_ch.key = okey;
endmodule
`default_nettype wire

FILE: verif/qs3w_checker.sv
// Checker that predicts the sorted record stream and compares it with the engine output.
`default_nettype none
module qs3w_checker #(
	parameter int MAX_ELEMS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	qs3w_if           in_mon,
	qs3w_if           out_mon,
	output int        errors,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] key;
		logic        [31:0] payload;
		logic               last;
	} sorted_rec_t;

	sorted_rec_t        sorted_q[$];
	logic signed [31:0] key_mem[MAX_ELEMS];
	logic        [31:0] pay_mem[MAX_ELEMS];
	int                 rec_count;

	function automatic void swap_recs(int a, int b);
		logic signed [31:0] k;
		logic        [31:0] p;
		k = key_mem[a];
		p = pay_mem[a];
		key_mem[a] = key_mem[b];
		pay_mem[a] = pay_mem[b];
		key_mem[b] = k;
		pay_mem[b] = p;
	endfunction

	// Three-way partition quicksort with an explicit LIFO of pending ranges.
	function automatic void sort_records();
		int                 lo_stk[MAX_ELEMS];
		int                 hi_stk[MAX_ELEMS];
		int                 sp;
		int                 lo;
		int                 hi;
		int                 lt;
		int                 cur;
		int                 gt;
		logic signed [31:0] piv;
		sp = 0;
		if (rec_count < 2)
			return;
		lo_stk[0] = 0;
		hi_stk[0] = rec_count - 1;
		sp = 1;
		while (sp > 0) begin
			sp--;
			lo = lo_stk[sp];
			hi = hi_stk[sp];
			if (lo >= hi)
				continue;
			piv = key_mem[hi];
			lt = lo;
			cur = lo;
			gt = hi;
			while (cur < gt) begin
				if (key_mem[cur] < piv) begin
					swap_recs(lt, cur);
					lt++;
					cur++;
				end else if (key_mem[cur] == piv) begin
					cur++;
				end else begin
					gt--;
					swap_recs(gt, cur);
				end
			end
			swap_recs(gt, hi);
			if (lt > lo + 1 && sp < MAX_ELEMS) begin
				lo_stk[sp] = lo;
				hi_stk[sp] = lt - 1;
				sp++;
			end
			if (gt + 1 < hi && sp < MAX_ELEMS) begin
				lo_stk[sp] = gt + 1;
				hi_stk[sp] = hi;
				sp++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sorted_rec_t got;
		sorted_rec_t want;
		if (!arst_n) begin
			rec_count = 0;
			errors    <= 0;
			pending   <= 0;
		end else begin
			if (in_mon.valid && in_mon.ready) begin
				if (rec_count < MAX_ELEMS) begin
					key_mem[rec_count] = in_mon.key;
					pay_mem[rec_count] = in_mon.payload;
					rec_count = rec_count + 1;
				end
				if (in_mon.last) begin
					sort_records();
					for (int i = 0; i < rec_count; i++) begin
						want.key     = key_mem[i];
						want.payload = pay_mem[i];
						want.last    = (i == rec_count - 1);
						sorted_q.push_back(want);
					end
					rec_count = 0;
				end
			end
			if (out_mon.valid && out_mon.ready) begin
				got.key     = out_mon.key;
				got.payload = out_mon.payload;
				got.last    = out_mon.last;
				if (sorted_q.size() == 0) begin
					$display("%t: unexpected record key=%h payload=%h last=%b",
						$realtime, got.key, got.payload, got.last);
					errors <= errors + 1;
				end else begin
					want = sorted_q.pop_front();
					if (got.key !== want.key || got.payload !== want.payload
						|| got.last !== want.last) begin
						$display("%t: expected %h/%h/%b actual %h/%h/%b",
							$realtime, want.key, want.payload, want.last,
							got.key, got.payload, got.last);
						errors <= errors + 1;
					end
				end
			end
			pending <= sorted_q.size();
		end
	end
endmodule
`default_nettype wire

FILE: verif/tb_quicksort_three_way_engine_core.sv
// Testbench top that feeds record sets to the sort engine and reports the verdict.
`default_nettype none
module tb_quicksort_three_way_engine_core;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   idle_pct;
	int   stall_pct;
	logic hold_req;
	logic hold_done;
	int   hold_cnt;
	int   item_total;

	qs3w_if #(.KeyW(32)) in_ch ();
	qs3w_if #(.KeyW(32)) out_ch ();

	quicksort_three_way_engine_core #(.MAX_ELEMS(64), .KEY_BITS(32)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	qs3w_checker #(.MAX_ELEMS(64)) chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_mon  (in_ch),
		.out_mon (out_ch),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Long hold-off counter, started once on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_cnt  <= 3000;
			hold_done <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// Receiver: random stalls, plus the long hold-off so the engine backs up.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if ((hold_req && !hold_done) || hold_cnt > 0) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic logic signed [31:0] pick_key(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 7)) - 4;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh0000_0000;
					default: return -32'sd1;
				endcase
			end
		endcase
	endfunction

	task automatic send_record(logic signed [31:0] k, logic [31:0] p, logic fin);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.key     <= k;
		in_ch.payload <= p;
		in_ch.last    <= fin;
		do
			@(posedge clk);
		while (!in_ch.ready);
		item_total++;
	endtask

	task automatic send_set(int n, int mode);
		for (int i = 0; i < n; i++)
			send_record(pick_key(mode), $urandom, i == n - 1);
		in_ch.valid <= 1'b0;
	endtask

	task automatic set_phase(int ph);
		case (ph % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 67; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 67; end
			default: begin idle_pct = 36; stall_pct = 36; end
		endcase
	endtask

	initial begin
		#4_000_000;
		$display("[quicksort_three_way_engine_core] ERROR");
		$finish;
	end

	initial begin
		int n;
		int sel;
		int set_idx;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.key     = '0;
		in_ch.payload = '0;
		in_ch.last    = 1'b0;
		hold_req      = 1'b0;
		idle_pct      = 0;
		stall_pct     = 0;
		item_total    = 0;
		set_idx       = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets: extreme keys, a lone record, equal keys, sorted runs.
		send_record(32'sh7fff_ffff, 32'hffff_ffff, 1'b0);
		send_record(32'sh8000_0000, 32'h0000_0000, 1'b0);
		send_record(-32'sd1, 32'haaaa_aaaa, 1'b0);
		send_record(32'sd0, 32'h5555_5555, 1'b0);
		send_record(32'sd1, 32'h1234_5678, 1'b1);
		send_record(32'sd42, 32'hdead_beef, 1'b1);
		for (int i = 0; i < 4; i++)
			send_record(-32'sd7, i, i == 3);
		for (int i = 0; i < 5; i++)
			send_record(i * 100 - 200, i, i == 4);
		for (int i = 0; i < 5; i++)
			send_record(200 - i * 100, i, i == 4);
		in_ch.valid <= 1'b0;

		// Random sets, mostly small; a few fill or overflow the store.
		while (item_total < 260) begin
			set_phase(set_idx);
			sel = $urandom_range(0, 99);
			if (sel < 80)
				n = $urandom_range(1, 12);
			else if (sel < 92)
				n = $urandom_range(13, 63);
			else
				n = $urandom_range(64, 68);
			if (set_idx == 6) begin
				// The long hold-off lands while this set leaves and the next one waits.
				hold_req <= 1'b1;
				send_set(40, 0);
				send_set(8, 1);
			end else begin
				send_set(n, $urandom_range(0, 2));
			end
			set_idx++;
		end

		// Let the checker register the last set before waiting for the drain.
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[quicksort_three_way_engine_core] OK");
		else
			$display("[quicksort_three_way_engine_core] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
